>>> src/seconds_to_calendar_date_unit_defines.svh
// Assertion macros for the seconds-to-calendar-date unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, ignored while reset is high.
`define SCD_ASSERT_RST(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define SCD_ASSERT_ON(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCD_ASSERT_RST(lbl, clk_i, rst_i, prop, msg)
`define SCD_ASSERT_ON(lbl, clk_i, prop, msg)
`endif

`endif

>>> src/scd_pkg.sv
// Shared types and constants of the seconds-to-calendar-date pipeline.
// Depends on nothing; imported by every module of the unit.
package scd_pkg;

  localparam logic [11:0] EPOCH_YEAR     = 12'd1912;
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [16:0] SECS_PER_MIN   = 17'd60;
  localparam logic [10:0] MINS_PER_HOUR  = 11'd60;
  localparam logic [10:0] DAYS_LEAP      = 11'd366;
  localparam logic [10:0] DAYS_COMMON    = 11'd365;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
  localparam logic [15:0] DAYS_PER_WEEK  = 16'd7;

  // Start of the second, third and fourth year inside a four-year cycle.
  localparam logic [10:0] YEAR1_START = DAYS_LEAP;
  localparam logic [10:0] YEAR2_START = DAYS_LEAP + DAYS_COMMON;
  localparam logic [10:0] YEAR3_START = DAYS_LEAP + DAYS_COMMON + DAYS_COMMON;

  // Reciprocal constants: q = (x * RECIP) >> SHIFT is exact over the value range.
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // (secs >> 7) / 675
  localparam int          DAY_SHIFT   = 35;
  localparam logic [16:0] CYCLE_RECIP = 17'd91868;     // days / 1461
  localparam int          CYCLE_SHIFT = 27;
  localparam logic [16:0] WEEK_RECIP  = 17'd74899;     // days / 7
  localparam int          WEEK_SHIFT  = 19;
  localparam logic [17:0] HOUR_RECIP  = 18'd149131;    // sod / 3600
  localparam int          HOUR_SHIFT  = 29;
  localparam logic [17:0] MIN_RECIP   = 18'd139811;    // sod / 60
  localparam int          MIN_SHIFT   = 23;

  typedef logic [8:0] doy_t;
  typedef doy_t month_table_t [12];

  // First day of each month, counted from zero.
  localparam month_table_t MONTH_START_LEAP = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };
  localparam month_table_t MONTH_START_COMMON = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Whole days and second of day.
  typedef struct packed {
    logic [15:0] days;
    logic [16:0] sod;
  } scd_split_t;

  // Everything but the month split.
  typedef struct packed {
    logic        leap;
    doy_t        doy;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } scd_fields_t;

endpackage

>>> src/scd_day_split.sv
// Two-stage split of the seconds count into whole days and second of day.
// Depends on scd_pkg.
module scd_day_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         seconds_count,
  output logic                out_valid,
  input  logic                out_stall,
  output scd_pkg::scd_split_t out_data
);
  import scd_pkg::*;

  logic        a_valid;
  logic [15:0] a_days;
  logic [31:0] a_secs;
  logic        a_stall;
  logic        b_stall;
  logic [50:0] day_prod;
  logic [32:0] day_base;
  logic [16:0] sod_calc;

  assign b_stall  = out_valid & out_stall;
  assign a_stall  = a_valid & b_stall;
  assign in_stall = a_stall;

  // Divide by 86400 as a shift by 7 and a reciprocal multiply by 1/675.
  assign day_prod = 51'(seconds_count[31:7]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_stall && in_valid) begin
      a_days <= day_prod[DAY_SHIFT +: 16];
      a_secs <= seconds_count;
    end
  end

  // Remainder fits 17 bits, so the low bits of the difference are enough.
  assign day_base = 33'(a_days) * 33'(SECS_PER_DAY);
  assign sod_calc = a_secs[16:0] - day_base[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!b_stall) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b_stall && a_valid) begin
      out_data.days <= a_days;
      out_data.sod  <= sod_calc;
    end
  end

endmodule

>>> src/scd_field_calc.sv
// Three-stage pipeline: quotients, remainders, then year and day of year.
// Depends on scd_pkg.
module scd_field_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scd_pkg::scd_split_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scd_pkg::scd_fields_t out_data
);
  import scd_pkg::*;

  // Stage C: quotients by reciprocal multiply.
  logic        c_valid;
  logic [15:0] c_days;
  logic [16:0] c_sod;
  logic [5:0]  c_cyc;
  logic [12:0] c_wq;
  logic [4:0]  c_hour;
  logic [10:0] c_mins;
  // Stage D: remainders.
  logic        d_valid;
  logic [10:0] d_dcyc;
  logic [5:0]  d_cyc;
  logic [4:0]  d_hour;
  logic [5:0]  d_minute;
  logic [5:0]  d_second;
  logic [2:0]  d_weekday;

  logic        c_stall;
  logic        d_stall;
  logic        e_stall;

  logic [32:0] cyc_prod;
  logic [32:0] wq_prod;
  logic [34:0] hour_prod;
  logic [34:0] mins_prod;

  logic [15:0] cyc_base;
  logic [15:0] dcyc_full;
  logic [15:0] week_base;
  logic [15:0] wd_full;
  logic [10:0] hour_base;
  logic [10:0] min_full;
  logic [16:0] min_base;
  logic [16:0] sec_full;

  logic [1:0]  yic;
  logic [10:0] year_off;
  logic [10:0] doy_full;

  assign e_stall  = out_valid & out_stall;
  assign d_stall  = d_valid & e_stall;
  assign c_stall  = c_valid & d_stall;
  assign in_stall = c_stall;

  assign cyc_prod  = 33'(in_data.days) * 33'(CYCLE_RECIP);
  assign wq_prod   = 33'(in_data.days) * 33'(WEEK_RECIP);
  assign hour_prod = 35'(in_data.sod) * 35'(HOUR_RECIP);
  assign mins_prod = 35'(in_data.sod) * 35'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (!c_stall) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!c_stall && in_valid) begin
      c_days <= in_data.days;
      c_sod  <= in_data.sod;
      c_cyc  <= cyc_prod[CYCLE_SHIFT +: 6];
      c_wq   <= wq_prod[WEEK_SHIFT +: 13];
      c_hour <= hour_prod[HOUR_SHIFT +: 5];
      c_mins <= mins_prod[MIN_SHIFT +: 11];
    end
  end

  // Each remainder is small, so keep only its low bits.
  assign cyc_base  = 16'(c_cyc) * 16'(DAYS_PER_CYCLE);
  assign dcyc_full = c_days - cyc_base;
  assign week_base = 16'(c_wq) * DAYS_PER_WEEK;
  assign wd_full   = c_days - week_base;
  assign hour_base = 11'(c_hour) * MINS_PER_HOUR;
  assign min_full  = c_mins - hour_base;
  assign min_base  = 17'(c_mins) * SECS_PER_MIN;
  assign sec_full  = c_sod - min_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (!d_stall) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!d_stall && c_valid) begin
      d_dcyc    <= dcyc_full[10:0];
      d_cyc     <= c_cyc;
      d_hour    <= c_hour;
      d_minute  <= min_full[5:0];
      d_second  <= sec_full[5:0];
      d_weekday <= wd_full[2:0];
    end
  end

  // Pick the year inside the cycle; the first year is the leap year.
  always_comb begin
    if (d_dcyc >= YEAR3_START) begin
      yic      = 2'd3;
      year_off = YEAR3_START;
    end else if (d_dcyc >= YEAR2_START) begin
      yic      = 2'd2;
      year_off = YEAR2_START;
    end else if (d_dcyc >= YEAR1_START) begin
      yic      = 2'd1;
      year_off = YEAR1_START;
    end else begin
      yic      = 2'd0;
      year_off = 11'd0;
    end
    doy_full = d_dcyc - year_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!e_stall) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!e_stall && d_valid) begin
      out_data.leap    <= (yic == 2'd0);
      out_data.doy     <= doy_full[8:0];
      out_data.year    <= EPOCH_YEAR + {4'd0, d_cyc, 2'b00} + {10'd0, yic};
      out_data.hour    <= d_hour;
      out_data.minute  <= d_minute;
      out_data.second  <= d_second;
      out_data.weekday <= d_weekday;
    end
  end

endmodule

>>> src/scd_month_lookup.sv
// Output stage: splits day of year into month and day of month.
// Depends on scd_pkg.
module scd_month_lookup (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scd_pkg::scd_fields_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [11:0]          year,
  output logic [3:0]           month,
  output logic [4:0]           day_of_month,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           second,
  output logic [2:0]           weekday
);
  import scd_pkg::*;

  month_table_t starts;
  logic [3:0]   mon_idx;
  doy_t         day_full;
  logic         f_stall;

  assign f_stall  = out_valid & out_stall;
  assign in_stall = f_stall;

  // Compare against every month start at once; the last one passed wins.
  always_comb begin
    starts  = in_data.leap ? MONTH_START_LEAP : MONTH_START_COMMON;
    mon_idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (in_data.doy >= starts[m]) begin
        mon_idx = 4'(m);
      end
    end
    day_full = in_data.doy - starts[mon_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!f_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!f_stall && in_valid) begin
      year         <= in_data.year;
      month        <= mon_idx + 4'd1;
      day_of_month <= day_full[4:0] + 5'd1;
      hour         <= in_data.hour;
      minute       <= in_data.minute;
      second       <= in_data.second;
      weekday      <= in_data.weekday;
    end
  end

endmodule

>>> src/seconds_to_calendar_date_unit.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------------
// input    | in        | in_valid / in_stall | seconds_count
// output   | out       | out_valid/out_stall | year month day_of_month hour minute
//          |           |                     | second weekday
//
// One transaction enters per cycle unless in_stall is high, and passes six register
// stages (two for the day split, three for the calendar fields, one for the month
// lookup). The depth is set by the chain of reciprocal multiplies.
// Reset (rst, synchronous) clears the valid bits of all six stages; data
// registers keep whatever they hold. A stall on the output holds the last stage
// and backs up stage by stage, so bubbles are squeezed out and nothing is lost.
//
// Top level of the seconds-to-calendar-date unit.
// Depends on scd_pkg, scd_day_split, scd_field_calc, scd_month_lookup and the defines header.
`include "seconds_to_calendar_date_unit_defines.svh"

module seconds_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] seconds_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday
);
  import scd_pkg::*;

  // Days and second of day, between the split and the field stages.
  scd_split_t  split_data;
  logic        split_valid;
  logic        split_stall;
  // Calendar fields still waiting for the month split.
  scd_fields_t fields_data;
  logic        fields_valid;
  logic        fields_stall;
  // Range checks on the delivered date.
  logic        month_ok;
  logic        time_ok;
  logic        day_ok;
  logic        leap_ok;

  // Split the count into whole days and second of day.
  scd_day_split u_split (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .seconds_count (seconds_count),
    .out_valid     (split_valid),
    .out_stall     (split_stall),
    .out_data      (split_data)
  );

  // Derive cycle, year, day of year, time of day and weekday.
  scd_field_calc u_fields (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_stall  (split_stall),
    .in_data   (split_data),
    .out_valid (fields_valid),
    .out_stall (fields_stall),
    .out_data  (fields_data)
  );

  // Look up the month and drive the output registers.
  scd_month_lookup u_month (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (fields_valid),
    .in_stall     (fields_stall),
    .in_data      (fields_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  assign month_ok = (month >= 4'd1) && (month <= 4'd12);
  assign time_ok  = (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);
  assign day_ok   = (day_of_month != 5'd0) && (weekday != 3'd7);
  // The twenty-ninth of February exists only in the leap year of a cycle.
  assign leap_ok  = !(month == 4'd2 && day_of_month == 5'd29) || (year[1:0] == 2'b00);

  // Reset must drain every stage, so no result can follow it directly.
  `SCD_ASSERT_ON(a_reset_drains, clk, rst |=> !out_valid, "result valid right after reset")
  `SCD_ASSERT_RST(a_month_range, clk, rst, out_valid |-> month_ok, "month out of range")
  `SCD_ASSERT_RST(a_time_range, clk, rst, out_valid |-> time_ok, "time of day out of range")
  `SCD_ASSERT_RST(a_day_range, clk, rst, out_valid |-> day_ok, "day or weekday out of range")
  `SCD_ASSERT_RST(a_leap_day, clk, rst, out_valid |-> leap_ok, "leap day outside a leap year")

endmodule
